// ===== sv/cdq_pkg.sv =====
// Shared constants, codes and pointer helpers for the circular deque.
// No dependencies.
package cdq_pkg;

  localparam int SLOTS     = 8;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 3;
  localparam int CNT_W     = (IDX_W + 1 > CNT_OUT_W) ? IDX_W + 1 : CNT_OUT_W;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  function automatic idx_t step_up(idx_t i);
    return (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic idx_t step_down(idx_t i);
    return (i == '0) ? IDX_W'(SLOTS - 1) : i - 1'b1;
  endfunction

  function automatic cnt_t count_of(idx_t h, idx_t t);
    cnt_t hh;
    cnt_t tt;
    hh = CNT_W'(h);
    tt = CNT_W'(t);
    return (t >= h) ? tt - hh : tt + CNT_W'(SLOTS) - hh;
  endfunction

endpackage

// ===== sv/cdq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/circular_deque.sv =====
// Circular deque top level: pointer control around one ring RAM.
// Depends on cdq_pkg and cdq_ram.
// The read word is registered in the RAM, then moved to the output register.
// No new command is accepted while one is in flight or a result is stalled.
// Reset clears head, tail and handshake state; RAM contents are not cleared.
module circular_deque (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cdq_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [cdq_pkg::DATA_W-1:0]   in_push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cdq_pkg::DATA_W-1:0]   out_read_value,
  output logic [cdq_pkg::STAT_W-1:0]          out_status,
  output logic                                out_empty_flag,
  output logic                                out_full_flag,
  output logic [cdq_pkg::CNT_OUT_W-1:0]       out_entry_count
);
  import cdq_pkg::*;

  idx_t              head_r, head_nxt;
  idx_t              tail_r, tail_nxt;
  logic              pend_r;
  logic              rd_use_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_value_r;
  stat_t             out_status_r;
  logic              out_empty_r;
  logic              out_full_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  logic              acc;
  logic              empty_now, full_now;
  logic              we, re;
  idx_t              waddr, raddr;
  stat_t             stat;
  logic [DATA_W-1:0] rdata;
  cnt_t              cnt_nxt;

  assign in_ready  = !pend_r && (!out_valid_r || out_ready);
  assign acc       = in_valid && in_ready;
  assign empty_now = (head_r == tail_r);
  assign full_now  = (step_up(tail_r) == head_r);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = head_r;
    raddr    = step_up(head_r);
    stat     = STAT_DONE;
    unique case (in_cmd)
      CMD_PUSH_FRONT: begin
        if (full_now) begin
          stat = STAT_FULL;
        end else begin
          we       = 1'b1;
          waddr    = head_r;
          head_nxt = step_down(head_r);
        end
      end
      CMD_PUSH_REAR: begin
        if (full_now) begin
          stat = STAT_FULL;
        end else begin
          we       = 1'b1;
          waddr    = step_up(tail_r);
          tail_nxt = step_up(tail_r);
        end
      end
      CMD_POP_FRONT: begin
        if (empty_now) begin
          stat = STAT_EMPTY;
        end else begin
          re       = 1'b1;
          raddr    = step_up(head_r);
          head_nxt = step_up(head_r);
        end
      end
      CMD_POP_REAR: begin
        if (empty_now) begin
          stat = STAT_EMPTY;
        end else begin
          re       = 1'b1;
          raddr    = tail_r;
          tail_nxt = step_down(tail_r);
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty_now) begin
          stat = STAT_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = step_up(head_r);
        end
      end
      CMD_PEEK_REAR: begin
        if (empty_now) begin
          stat = STAT_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = tail_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_nxt = count_of(head_nxt, tail_nxt);

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (acc && we),
    .waddr (waddr),
    .wdata (in_push_value),
    .re    (acc && re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
      pend_r <= acc;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result fields other than the read word are known at accept
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_use_r     <= re;
      out_status_r <= stat;
      out_empty_r  <= (head_nxt == tail_nxt);
      out_full_r   <= (step_up(tail_nxt) == head_nxt);
      out_count_r  <= cnt_nxt[CNT_OUT_W-1:0];
    end
    if (pend_r) begin
      out_read_value_r <= rd_use_r ? rdata : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_empty_flag  = out_empty_r;
  assign out_full_flag   = out_full_r;
  assign out_entry_count = out_count_r;

  a_pend_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r)
    else $error("result not presented after RAM read");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (pend_r && !in_ready))
    else $error("beat accepted while previous command in flight");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(head_r) < CNT_W'(SLOTS)) && (CNT_W'(tail_r) < CNT_W'(SLOTS)))
    else $error("pointer out of ring range");

  a_refused_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && stat != STAT_DONE) |=> ($stable(head_r) && $stable(tail_r)))
    else $error("refused command moved a pointer");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_DONE) |-> (out_read_value_r == '0))
    else $error("refused command returned nonzero word");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for circular_deque: directed and random commands at both ends,
// each result beat checked against a behavioral deque held in a scoreboard class.
// Depends on cdq_pkg and the circular_deque RTL.
module tb;
  import cdq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
  localparam int PHASE_ITEMS  = 425;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    stat_t                    status;
    logic                     empty_flag;
    logic                     full_flag;
    logic [CNT_OUT_W-1:0]     entry_count;
  } deque_result_t;

  class deque_tracker;
    logic [DATA_W-1:0] ring [SLOTS];
    idx_t              head;
    idx_t              tail;
    deque_result_t     pending_results[$];
    int                errors;
    int                checked;
    int                full_refusals;
    int                empty_refusals;

    function new();
      head = '0;
      tail = '0;
      errors = 0;
      checked = 0;
      full_refusals = 0;
      empty_refusals = 0;
    endfunction

    function idx_t next_slot(idx_t i);
      return (int'(i) == SLOTS - 1) ? '0 : i + idx_t'(1);
    endfunction

    function idx_t prev_slot(idx_t i);
      return (i == '0) ? idx_t'(SLOTS - 1) : i - idx_t'(1);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] word);
      deque_result_t r;
      logic          was_empty;
      logic          was_full;
      was_empty = (head == tail);
      was_full  = (next_slot(tail) == head);
      r.read_value = '0;
      r.status     = STAT_DONE;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (was_full) r.status = STAT_FULL;
          else begin
            ring[head] = word;
            head = prev_slot(head);
          end
        end
        CMD_PUSH_REAR: begin
          if (was_full) r.status = STAT_FULL;
          else begin
            tail = next_slot(tail);
            ring[tail] = word;
          end
        end
        CMD_POP_FRONT: begin
          if (was_empty) r.status = STAT_EMPTY;
          else begin
            head = next_slot(head);
            r.read_value = ring[head];
          end
        end
        CMD_POP_REAR: begin
          if (was_empty) r.status = STAT_EMPTY;
          else begin
            r.read_value = ring[tail];
            tail = prev_slot(tail);
          end
        end
        CMD_PEEK_FRONT: begin
          if (was_empty) r.status = STAT_EMPTY;
          else r.read_value = ring[next_slot(head)];
        end
        CMD_PEEK_REAR: begin
          if (was_empty) r.status = STAT_EMPTY;
          else r.read_value = ring[tail];
        end
        default: ;
      endcase
      if (r.status == STAT_FULL) full_refusals++;
      if (r.status == STAT_EMPTY) empty_refusals++;
      r.empty_flag  = (head == tail);
      r.full_flag   = (next_slot(tail) == head);
      r.entry_count = CNT_OUT_W'((int'(tail) + SLOTS - int'(head)) % SLOTS);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, longint exp_val, longint got_val);
      if (exp_val != got_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] value, logic [STAT_W-1:0] status,
                               logic empty_flag, logic full_flag,
                               logic [CNT_OUT_W-1:0] entry_count);
      deque_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      checked++;
      compare_field("read_value", e.read_value, value);
      compare_field("status", e.status, status);
      compare_field("empty_flag", e.empty_flag, empty_flag);
      compare_field("full_flag", e.full_flag, full_flag);
      compare_field("entry_count", e.entry_count, entry_count);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic [STAT_W-1:0]        out_status;
  logic                     out_empty_flag;
  logic                     out_full_flag;
  logic [CNT_OUT_W-1:0]     out_entry_count;

  deque_tracker tracker = new();
  int snd_idle_pct = 19;
  int rcv_idle_pct = 55;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int sent = 0;

  circular_deque u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_empty_flag  (out_empty_flag),
    .out_full_flag   (out_full_flag),
    .out_entry_count (out_entry_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        tracker.check_result(out_read_value, out_status, out_empty_flag,
                             out_full_flag, out_entry_count);
      if (in_valid && in_ready)
        tracker.note_command(in_cmd, in_push_value);
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] word);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_push_value <= word;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // bursts biased toward pushes or pops so full and empty are hit often
  task automatic run_random_phase(input int n);
    int               done_items;
    int               burst;
    int               push_pct;
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] word;
    done_items = 0;
    while (done_items < n) begin
      burst = $urandom_range(20, 4);
      case ($urandom_range(2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      repeat (burst) begin
        if ($urandom_range(99) < 3)
          cmd = $urandom_range(1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
        else if ($urandom_range(99) < push_pct)
          cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        else if ($urandom_range(99) < 70)
          cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
        else
          cmd = $urandom_range(1) ? CMD_PEEK_REAR : CMD_PEEK_FRONT;
        case ($urandom_range(9))
          0: word = 32'h8000_0000;
          1: word = 32'h7FFF_FFFF;
          default: word = $urandom;
        endcase
        send_command(cmd, word);
        done_items++;
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty deque: refusals and unused codes
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_REAR, 32'h0);
    send_command(CMD_PEEK_FRONT, 32'h0);
    send_command(CMD_PEEK_REAR, 32'h0);
    send_command(CMD_UNUSED_6, 32'hFFFF_FFFF);
    send_command(CMD_UNUSED_7, 32'h0);
    // extreme words at both ends, then fill up
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_command(CMD_PUSH_REAR, 32'h0000_0000);
    send_command(CMD_PEEK_FRONT, 32'h0);
    send_command(CMD_PEEK_REAR, 32'h0);
    send_command(CMD_PUSH_REAR, 32'h5555_5555);
    send_command(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_command(CMD_PUSH_REAR, 32'h1234_5678);
    // full deque: refusals at both ends
    send_command(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
    send_command(CMD_PUSH_REAR, 32'hDEAD_BEEF);
    send_command(CMD_UNUSED_6, 32'h0);
    repeat (3) begin
      send_command(CMD_POP_FRONT, 32'h0);
      send_command(CMD_POP_REAR, 32'h0);
    end
    send_command(CMD_POP_REAR, 32'h0);
    drain_results();

    hold_asked++;
    run_random_phase(PHASE_ITEMS);
    drain_results();

    snd_idle_pct = 55;
    rcv_idle_pct = 19;
    run_random_phase(PHASE_ITEMS);
    drain_results();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_asked++;
    run_random_phase(PHASE_ITEMS);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d result beats checked, %0d errors",
             sent, tracker.checked, tracker.errors);
    $display("refusals seen: %0d on full, %0d on empty", tracker.full_refusals,
             tracker.empty_refusals);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[circular_deque] OK");
    end else begin
      $display("[circular_deque] ERROR");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("timeout: %0d results still outstanding", tracker.pending());
    $display("[circular_deque] ERROR");
    $finish;
  end

endmodule
